// ===== hw/rtl/button_press_mode_controller_top_macros.svh =====
// assertion helpers for the button press mode controller
`ifndef BUTTON_PRESS_MODE_CONTROLLER_TOP_MACROS_SVH
`define BUTTON_PRESS_MODE_CONTROLLER_TOP_MACROS_SVH

// same-cycle implication
`define BPMC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bpmc assertion failed");

// next-cycle implication
`define BPMC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bpmc assertion failed");

`endif

// ===== hw/rtl/bpmc_pkg.sv =====
`default_nettype none
package bpmc_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;
  localparam int unsigned InTdataW  = 40;
  localparam int unsigned OutTdataW = 8;

  localparam logic [CfgW-1:0] DebounceReset  = 16'd30;
  localparam logic [CfgW-1:0] LongPressReset = 16'd1000;
  localparam logic [CfgW-1:0] RefreshReset   = 16'd200;

  typedef enum logic [1:0] {
    RegDebounce  = 2'd0,
    RegLongPress = 2'd1,
    RegRefresh   = 2'd2,
    RegNone      = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [CfgW-1:0] debounce_time;
    logic [CfgW-1:0] long_press_time;
    logic [CfgW-1:0] refresh_period;
  } cfg_t;

  typedef struct packed {
    logic error_screen;
    logic refresh_request;
    logic long_press_event;
    logic short_press_event;
    logic raw_log_on;
    logic view_mode;
  } result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bpmc_cfg_regs.sv =====
`default_nettype none
module bpmc_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bpmc_pkg::AddrW-1:0]    paddr,
  input  wire logic [bpmc_pkg::DataW-1:0]    pwdata,
  output      logic [bpmc_pkg::DataW-1:0]    prdata,
  output      logic                          pready,
  output      bpmc_pkg::cfg_t                cfg_o
);

  bpmc_pkg::cfg_t cfg_q;
  bpmc_pkg::reg_idx_e idx;
  logic wr_en;

  assign idx    = bpmc_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_time   <= bpmc_pkg::DebounceReset;
      cfg_q.long_press_time <= bpmc_pkg::LongPressReset;
      cfg_q.refresh_period  <= bpmc_pkg::RefreshReset;
    end else if (wr_en) begin
      unique case (idx)
        bpmc_pkg::RegDebounce:  cfg_q.debounce_time   <= pwdata[bpmc_pkg::CfgW-1:0];
        bpmc_pkg::RegLongPress: cfg_q.long_press_time <= pwdata[bpmc_pkg::CfgW-1:0];
        bpmc_pkg::RegRefresh:   cfg_q.refresh_period  <= pwdata[bpmc_pkg::CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      bpmc_pkg::RegDebounce:  prdata = {16'd0, cfg_q.debounce_time};
      bpmc_pkg::RegLongPress: prdata = {16'd0, cfg_q.long_press_time};
      bpmc_pkg::RegRefresh:   prdata = {16'd0, cfg_q.refresh_period};
      default:                prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/bpmc_core.sv =====
`default_nettype none
module bpmc_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          step_i,
  input  wire bpmc_pkg::cfg_t                cfg_i,
  input  wire logic [bpmc_pkg::TimeW-1:0]    now_i,
  input  wire logic                          level_i,
  input  wire logic                          err_i,
  output      bpmc_pkg::result_t             res_o
);

  logic                        samp_q, samp_d;
  logic                        stable_q, stable_d;
  logic [bpmc_pkg::TimeW-1:0]  change_q, change_d;
  logic [bpmc_pkg::TimeW-1:0]  press_q, press_d;
  logic                        ldone_q, ldone_d;
  logic                        mode_q, mode_d;
  logic                        rawlog_q, rawlog_d;
  logic                        err_q, err_d;
  logic [bpmc_pkg::TimeW-1:0]  rtime_q, rtime_d;

  logic                        deb_hit, long_hit, per_hit, forced;
  logic                        short_ev, long_ev;
  logic [bpmc_pkg::TimeW-1:0]  rtime_mid;

  always_comb begin
    err_d    = err_q | err_i;
    samp_d   = level_i;
    change_d = (level_i != samp_q) ? now_i : change_q;

    deb_hit  = (stable_q != samp_d) &&
               ((now_i - change_d) >= {16'd0, cfg_i.debounce_time});
    stable_d = deb_hit ? samp_d : stable_q;
    press_d  = press_q;
    ldone_d  = ldone_q;
    mode_d   = mode_q;
    short_ev = 1'b0;
    if (deb_hit) begin
      if (!samp_d) begin
        press_d = now_i;
        ldone_d = 1'b0;
      end else begin
        if (!ldone_q) begin
          mode_d   = ~mode_q;
          short_ev = 1'b1;
        end
        press_d = '0;
        ldone_d = 1'b0;
      end
    end

    // long press fires once per stable press
    long_hit = !stable_d && !ldone_d &&
               ((now_i - press_d) >= {16'd0, cfg_i.long_press_time});
    long_ev  = long_hit;
    rawlog_d = rawlog_q ^ long_hit;
    if (long_hit) begin
      ldone_d = 1'b1;
    end

    forced    = err_i | short_ev | long_ev;
    rtime_mid = forced ? now_i : rtime_q;
    per_hit   = (now_i - rtime_mid) >= {16'd0, cfg_i.refresh_period};
    rtime_d   = (forced | per_hit) ? now_i : rtime_q;

    res_o.view_mode         = mode_d;
    res_o.raw_log_on        = rawlog_d;
    res_o.short_press_event = short_ev;
    res_o.long_press_event  = long_ev;
    res_o.refresh_request   = forced | per_hit;
    res_o.error_screen      = err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samp_q   <= 1'b1;
      stable_q <= 1'b1;
      change_q <= '0;
      press_q  <= '0;
      ldone_q  <= 1'b0;
      mode_q   <= 1'b0;
      rawlog_q <= 1'b0;
      err_q    <= 1'b0;
      rtime_q  <= '0;
    end else if (step_i) begin
      samp_q   <= samp_d;
      stable_q <= stable_d;
      change_q <= change_d;
      press_q  <= press_d;
      ldone_q  <= ldone_d;
      mode_q   <= mode_d;
      rawlog_q <= rawlog_d;
      err_q    <= err_d;
      rtime_q  <= rtime_d;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/button_press_mode_controller_top.sv =====
// Button debounce with short and long press detection. Each poll carries a
// millisecond timestamp, the raw active-low button level and an error request;
// each poll yields exactly one result with the view and raw-log modes, the
// short and long press pulses, a display refresh request and the error screen
// select. One poll is accepted every clock cycle while results are taken; a
// poll taken into the input register has its result computed combinationally
// and loaded into the result register once that register is free or being read,
// with the per-poll compares and state update done in that same cycle. A
// result that is held back stalls the poll in the input register, and no new
// poll is taken until the result register frees up.
// Configuration is through the register port and must be written while idle.
`default_nettype none
module button_press_mode_controller_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // config port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [bpmc_pkg::AddrW-1:0]        paddr,
  input  wire logic [bpmc_pkg::DataW-1:0]        pwdata,
  output      logic [bpmc_pkg::DataW-1:0]        prdata,
  output      logic                              pready,
  // poll in
  input  wire logic                              s_axis_tvalid,
  output      logic                              s_axis_tready,
  // now_time[31:0], button_level[32], raise_error[33], zero pad
  input  wire logic [bpmc_pkg::InTdataW-1:0]     s_axis_tdata,
  // result out
  output      logic                              m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // view_mode[0], raw_log_on[1], short_press_event[2], long_press_event[3],
  // refresh_request[4], error_screen[5], zero pad
  output      logic [bpmc_pkg::OutTdataW-1:0]    m_axis_tdata
);

  bpmc_pkg::cfg_t     cfg;
  bpmc_pkg::result_t  res, res_q;

  logic                         in_valid_q;
  logic [bpmc_pkg::TimeW-1:0]   now_q;
  logic                         level_q;
  logic                         err_q;
  logic                         out_valid_q;
  logic                         advance;
  logic                         take_in;

  bpmc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;
  assign take_in       = s_axis_tvalid & s_axis_tready;

  bpmc_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .cfg_i   (cfg),
    .now_i   (now_q),
    .level_i (level_q),
    .err_i   (err_q),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take_in) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      now_q   <= s_axis_tdata[31:0];
      level_q <= s_axis_tdata[32];
      err_q   <= s_axis_tdata[33];
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, res_q};

  `include "button_press_mode_controller_top_macros.svh"

  `BPMC_ASSERT_NOW(a_events_exclusive, out_valid_q,
                   !(res_q.short_press_event && res_q.long_press_event))
  `BPMC_ASSERT_NOW(a_event_refresh,
                   out_valid_q && (res_q.short_press_event || res_q.long_press_event),
                   res_q.refresh_request)
  `BPMC_ASSERT_NEXT(a_advance_valid, advance, out_valid_q)
  `BPMC_ASSERT_NEXT(a_error_sticky, out_valid_q && res_q.error_screen,
                    res_q.error_screen)

endmodule
`default_nettype wire

// ===== bench/button_press_mode_controller_top_tb.sv =====
`timescale 1ns / 100ps

module button_press_mode_controller_top_tb;

  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic [31:0] stamp;
    logic        level;
    logic        err;
  } poll_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [bpmc_pkg::AddrW-1:0]     paddr = '0;
  logic [bpmc_pkg::DataW-1:0]     pwdata = '0;
  logic [bpmc_pkg::DataW-1:0]     prdata;
  logic                           pready;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  // now_time[31:0], button_level[32], raise_error[33], zero pad
  logic [bpmc_pkg::InTdataW-1:0]  s_axis_tdata = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  // view_mode[0], raw_log_on[1], short_press_event[2], long_press_event[3],
  // refresh_request[4], error_screen[5], zero pad
  logic [bpmc_pkg::OutTdataW-1:0] m_axis_tdata;

  button_press_mode_controller_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // button model state
  bpmc_pkg::cfg_t cfg = '{debounce_time: bpmc_pkg::DebounceReset,
                          long_press_time: bpmc_pkg::LongPressReset,
                          refresh_period: bpmc_pkg::RefreshReset};
  logic        btn_sampled = 1'b1;
  logic        btn_stable = 1'b1;
  logic [31:0] level_change_t = '0;
  logic [31:0] press_start_t = '0;
  logic        long_fired = 1'b0;
  logic        view_bit = 1'b0;
  logic        rawlog_bit = 1'b0;
  logic        err_latched = 1'b0;
  logic [31:0] refresh_t = '0;

  poll_t               poll_q[$];
  bpmc_pkg::result_t   expected_res_q[$];
  poll_t       cur_poll;
  int unsigned mismatches = 0;
  int unsigned polls_in = 0;
  int unsigned cycles = 0;
  int unsigned tx_wait = 0;
  int unsigned tx_calm = 0;
  int unsigned rx_wait = 0;
  int unsigned rx_calm = 0;
  int unsigned holdoff_left = 0;
  int unsigned next_holdoff = 60;

  logic [31:0] now_ms = '0;
  int unsigned step_hi = 4;
  int unsigned err_pct = 0;
  int unsigned phase_items = 0;

  function automatic logic span_met(logic [31:0] now, logic [31:0] start, logic [15:0] span);
    logic [31:0] diff;
    diff = now - start;
    return diff >= {16'h0, span};
  endfunction

  function automatic bpmc_pkg::result_t predict_poll(logic [31:0] now, logic lvl, logic err);
    bpmc_pkg::result_t r;
    r = '0;
    if (err) begin
      err_latched = 1'b1;
      r.refresh_request = 1'b1;
      refresh_t = now;
    end
    if (lvl != btn_sampled) begin
      btn_sampled = lvl;
      level_change_t = now;
    end
    if (btn_stable != btn_sampled && span_met(now, level_change_t, cfg.debounce_time)) begin
      btn_stable = btn_sampled;
      if (!btn_stable) begin
        press_start_t = now;
        long_fired = 1'b0;
      end else begin
        if (!long_fired) begin
          view_bit = ~view_bit;
          r.short_press_event = 1'b1;
          r.refresh_request = 1'b1;
          refresh_t = now;
        end
        press_start_t = '0;
        long_fired = 1'b0;
      end
    end
    if (!btn_stable && !long_fired && span_met(now, press_start_t, cfg.long_press_time)) begin
      rawlog_bit = ~rawlog_bit;
      r.long_press_event = 1'b1;
      r.refresh_request = 1'b1;
      refresh_t = now;
      long_fired = 1'b1;
    end
    if (span_met(now, refresh_t, cfg.refresh_period)) begin
      r.refresh_request = 1'b1;
      refresh_t = now;
    end
    r.view_mode = view_bit;
    r.raw_log_on = rawlog_bit;
    r.error_screen = err_latched;
    return r;
  endfunction

  function automatic int unsigned pick_gap(ref int unsigned calm);
    int unsigned r;
    if (calm != 0) begin
      calm = calm - 1;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic check_field(string name, logic exp, logic got);
    if (exp !== got) begin
      $error("%s: expected %0b, got %0b", name, exp, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk_i) begin : poll_driver
    logic offer;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      tx_wait <= 0;
    end else begin
      offer = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_res_q.push_back(predict_poll(cur_poll.stamp, cur_poll.level, cur_poll.err));
        polls_in <= polls_in + 1;
        offer = 1'b0;
      end
      if (!offer) begin
        if (tx_wait != 0) begin
          tx_wait <= tx_wait - 1;
        end else if (poll_q.size() != 0) begin
          cur_poll = poll_q.pop_front();
          s_axis_tdata <= {6'b0, cur_poll.err, cur_poll.level, cur_poll.stamp};
          tx_wait <= pick_gap(tx_calm);
          offer = 1'b1;
        end
      end
      s_axis_tvalid <= offer;
    end
  end

  // long hold-off so the block backs up and stalls its request side
  always @(posedge clk_i) begin : result_ready
    int unsigned g;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_wait <= 0;
      holdoff_left <= 0;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      m_axis_tready <= 1'b0;
    end else if (polls_in >= next_holdoff && poll_q.size() > 20) begin
      holdoff_left <= 150;
      next_holdoff <= next_holdoff + 200;
      m_axis_tready <= 1'b0;
    end else if (rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
      m_axis_tready <= 1'b0;
    end else begin
      g = (m_axis_tvalid && m_axis_tready) ? pick_gap(rx_calm) : 0;
      m_axis_tready <= (g == 0);
      rx_wait <= (g == 0) ? 0 : g - 1;
    end
  end

  always @(posedge clk_i) begin : result_monitor
    bpmc_pkg::result_t got;
    bpmc_pkg::result_t exp;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = bpmc_pkg::result_t'(m_axis_tdata[5:0]);
      if (expected_res_q.size() == 0) begin
        $error("unexpected result 0x%0h", m_axis_tdata);
        mismatches++;
      end else begin
        exp = expected_res_q.pop_front();
        check_field("view_mode", exp.view_mode, got.view_mode);
        check_field("raw_log_on", exp.raw_log_on, got.raw_log_on);
        check_field("short_press_event", exp.short_press_event, got.short_press_event);
        check_field("long_press_event", exp.long_press_event, got.long_press_event);
        check_field("refresh_request", exp.refresh_request, got.refresh_request);
        check_field("error_screen", exp.error_screen, got.error_screen);
      end
    end
  end

  task automatic wait_idle();
    @(negedge clk_i);
    while (poll_q.size() != 0 || s_axis_tvalid || expected_res_q.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic reg_write(bpmc_pkg::reg_idx_e idx, logic [15:0] val);
    logic [15:0] junk;
    junk = 16'($urandom_range(0, 65535));
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {junk, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      bpmc_pkg::RegDebounce:  cfg.debounce_time = val;
      bpmc_pkg::RegLongPress: cfg.long_press_time = val;
      bpmc_pkg::RegRefresh:   cfg.refresh_period = val;
      default: ;
    endcase
  endtask

  task automatic set_cfg(logic [15:0] dbt, logic [15:0] lpt, logic [15:0] rfp);
    wait_idle();
    repeat (4) @(posedge clk_i);
    reg_write(bpmc_pkg::RegDebounce, dbt);
    reg_write(bpmc_pkg::RegLongPress, lpt);
    reg_write(bpmc_pkg::RegRefresh, rfp);
  endtask

  task automatic queue_poll(logic [31:0] t, logic lvl, logic err);
    poll_t p;
    p.stamp = t;
    p.level = lvl;
    p.err = err;
    poll_q.push_back(p);
    now_ms = t;
    phase_items++;
  endtask

  task automatic queue_hold(logic lvl, int unsigned span);
    int unsigned dt;
    int unsigned acc;
    acc = 0;
    do begin
      dt = $urandom_range(0, step_hi);
      acc += dt;
      queue_poll(now_ms + dt, lvl, $urandom_range(0, 99) < err_pct);
    end while (acc < span);
  endtask

  // contact bounce shorter than the debounce time, settling on the given level
  task automatic queue_bounce(logic settle);
    int unsigned n;
    n = $urandom_range(0, 3);
    repeat (n) begin
      queue_poll(now_ms + $urandom_range(0, cfg.debounce_time / 2), ~settle, 1'b0);
      queue_poll(now_ms + $urandom_range(0, cfg.debounce_time / 2), settle, 1'b0);
    end
  endtask

  task automatic queue_random(int unsigned count);
    int unsigned dbt;
    int unsigned lpt;
    int unsigned pick;
    int unsigned hold;
    dbt = 32'(cfg.debounce_time);
    lpt = 32'(cfg.long_press_time);
    step_hi = (dbt + lpt) / 12 + 4;
    phase_items = 0;
    while (phase_items < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        case ($urandom_range(0, 2))
          0: hold = $urandom_range(0, dbt);
          1: hold = dbt + $urandom_range(0, lpt);
          default: hold = dbt + lpt + $urandom_range(0, 2 * step_hi);
        endcase
        queue_bounce(1'b0);
        queue_hold(1'b0, hold);
        queue_bounce(1'b1);
        queue_hold(1'b1, $urandom_range(0, dbt + 2 * cfg.refresh_period));
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 4))
          queue_poll(now_ms + $urandom_range(0, step_hi), $urandom_range(0, 1) == 1,
                     $urandom_range(0, 99) < err_pct);
      end else if (pick < 95) begin
        queue_poll($urandom, $urandom_range(0, 1) == 1, 1'b0);
      end else begin
        queue_poll(32'hFFFF_FFFF - $urandom_range(0, 4 * step_hi),
                   $urandom_range(0, 1) == 1, 1'b0);
      end
    end
  endtask

  initial begin : stimulus
    wait (rst_ni === 1'b1);
    // bounce, presses exactly at the debounce edge, short and long press
    queue_poll(32'd0, 1'b1, 1'b0);
    queue_poll(32'd10, 1'b0, 1'b0);
    queue_poll(32'd20, 1'b1, 1'b0);
    queue_poll(32'd25, 1'b0, 1'b0);
    queue_poll(32'd55, 1'b0, 1'b0);
    queue_poll(32'd300, 1'b0, 1'b0);
    queue_poll(32'd310, 1'b1, 1'b0);
    queue_poll(32'd339, 1'b1, 1'b0);
    queue_poll(32'd340, 1'b1, 1'b0);
    queue_poll(32'd400, 1'b0, 1'b0);
    queue_poll(32'd430, 1'b0, 1'b0);
    queue_poll(32'd1429, 1'b0, 1'b0);
    queue_poll(32'd1430, 1'b0, 1'b0);
    queue_poll(32'd2000, 1'b0, 1'b0);
    queue_poll(32'd2100, 1'b1, 1'b0);
    queue_poll(32'd2130, 1'b1, 1'b0);
    // timestamp wrap
    queue_poll(32'hFFFF_FFF0, 1'b0, 1'b0);
    queue_poll(32'h0000_000E, 1'b0, 1'b0);
    queue_poll(32'hFFFF_FFFF, 1'b1, 1'b0);
    queue_poll(32'h0000_0030, 1'b1, 1'b0);
    queue_random(100);

    set_cfg(16'd0, 16'd0, 16'd0);
    queue_random(70);
    set_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_random(60);
    set_cfg(16'd5, 16'd40, 16'd15);
    queue_random(100);
    set_cfg(16'($urandom_range(0, 50)), 16'($urandom_range(0, 400)),
            16'($urandom_range(0, 300)));
    queue_random(90);

    // error latching comes last since only reset clears it
    set_cfg(bpmc_pkg::DebounceReset, bpmc_pkg::LongPressReset, bpmc_pkg::RefreshReset);
    queue_poll(now_ms + 5, 1'b1, 1'b1);
    queue_poll(now_ms + 1, 1'b1, 1'b0);
    queue_poll(now_ms + 1, 1'b0, 1'b0);
    queue_poll(now_ms + 10, 1'b0, 1'b1);
    err_pct = 3;
    queue_random(100);

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
